// ===== hw/rtl/qapm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qapm_pkg: shared constants and helpers for the attitude PID mixer
// Fixed widths of the serial arithmetic units, filter and PID constants,
// register indexes, the CORDIC arctangent table and state saturation.
// ----------------------------------------------------------------------------
package qapm_pkg;

  localparam int STATE_W      = 32;
  localparam int CORDIC_STEPS = 16;
  localparam int ATAN_ENTRIES = 24;
  localparam int CORDIC_IW    = $clog2(ATAN_ENTRIES);

  // CORDIC vector and angle widths
  localparam int CW = 28;
  localparam int ZW = 26;

  // bit-serial multiplier: signed a times unsigned b
  localparam int MUL_AW = 34;
  localparam int MUL_BW = 24;
  localparam int MUL_PW = 58;

  // restoring divider: signed dividend, unsigned divisor
  localparam int DIV_NW = 58;
  localparam int DIV_DW = 20;
  localparam int DIV_CW = $clog2(DIV_NW);

  // integer square root
  localparam int SQ_NW    = 48;
  localparam int SQ_RW    = 25;
  localparam int SQ_STEPS = 24;
  localparam int SQ_CW    = $clog2(SQ_STEPS);

  localparam int PID_W = 40;

  localparam logic [ZW-1:0]     DEG180_Q16   = 26'd11796480;
  localparam logic [MUL_BW-1:0] GYRO_GAIN    = 24'd3937337;
  localparam logic [MUL_BW-1:0] KEEP_Q16     = 24'd62915;
  localparam logic [MUL_BW-1:0] BLEND_Q16    = 24'd2621;
  localparam logic [DIV_DW-1:0] USEC_PER_SEC = 20'd1000000;
  localparam logic [7:0]        THROTTLE_MIN = 8'd15;

  // gain register indexes
  localparam logic [2:0] REG_ROLL_KP  = 3'd0;
  localparam logic [2:0] REG_ROLL_KI  = 3'd1;
  localparam logic [2:0] REG_ROLL_KD  = 3'd2;
  localparam logic [2:0] REG_PITCH_KP = 3'd3;
  localparam logic [2:0] REG_PITCH_KI = 3'd4;
  localparam logic [2:0] REG_PITCH_KD = 3'd5;
  localparam logic [2:0] NUM_GAINS    = 3'd6;

  localparam logic [15:0] KP_RESET = 16'd5325;
  localparam logic [15:0] KI_RESET = 16'd41;
  localparam logic [15:0] KD_RESET = 16'd2048;

  // atan(2^-i) in Q10.16 degrees
  function automatic logic [ZW-1:0] atan_deg(input logic [CORDIC_IW-1:0] i);
    logic [ZW-1:0] r;
    unique case (i)
      5'd0:    r = 26'd2949120;
      5'd1:    r = 26'd1740967;
      5'd2:    r = 26'd919879;
      5'd3:    r = 26'd466945;
      5'd4:    r = 26'd234379;
      5'd5:    r = 26'd117304;
      5'd6:    r = 26'd58666;
      5'd7:    r = 26'd29335;
      5'd8:    r = 26'd14668;
      5'd9:    r = 26'd7334;
      5'd10:   r = 26'd3667;
      5'd11:   r = 26'd1833;
      5'd12:   r = 26'd917;
      5'd13:   r = 26'd458;
      5'd14:   r = 26'd229;
      5'd15:   r = 26'd115;
      5'd16:   r = 26'd57;
      5'd17:   r = 26'd29;
      5'd18:   r = 26'd14;
      5'd19:   r = 26'd7;
      5'd20:   r = 26'd4;
      5'd21:   r = 26'd2;
      5'd22:   r = 26'd1;
      default: r = '0;
    endcase
    return r;
  endfunction

  // saturate to signed state width
  function automatic logic signed [STATE_W-1:0] sat_state(input logic signed [63:0] v);
    logic signed [63:0] hi;
    logic signed [63:0] lo;
    hi = 64'sd2147483647;
    lo = -64'sd2147483648;
    if (v > hi) return hi[STATE_W-1:0];
    if (v < lo) return lo[STATE_W-1:0];
    return v[STATE_W-1:0];
  endfunction

endpackage

// ===== hw/rtl/qapm_mul.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qapm_mul: bit-serial shift-add multiplier
// Signed a times unsigned b, one multiplier bit per cycle, LSB first.
// Stops as soon as the remaining multiplier bits are all zero.
// ----------------------------------------------------------------------------
module qapm_mul import qapm_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic signed [MUL_AW-1:0] a_i,
  input  logic        [MUL_BW-1:0] b_i,
  output logic                     done_o,
  output logic signed [MUL_PW-1:0] p_o
);

  logic                     busy_q, done_q;
  logic signed [MUL_PW-1:0] a_q, p_q;
  logic        [MUL_BW-1:0] b_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
      end else if (busy_q && b_q == '0) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q <= MUL_PW'(a_i);
      b_q <= b_i;
      p_q <= '0;
    end else if (busy_q && b_q != '0) begin
      if (b_q[0]) p_q <= p_q + a_q;
      a_q <= a_q <<< 1;
      b_q <= b_q >> 1;
    end
  end

  assign done_o = done_q;
  assign p_o    = p_q;

endmodule

// ===== hw/rtl/qapm_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qapm_div: bit-serial restoring divider
// Signed dividend over unsigned nonzero divisor, quotient truncated toward
// zero. One quotient bit per cycle.
// ----------------------------------------------------------------------------
module qapm_div import qapm_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic signed [DIV_NW-1:0] n_i,
  input  logic        [DIV_DW-1:0] d_i,
  output logic                     done_o,
  output logic signed [DIV_NW-1:0] q_o
);

  logic              busy_q, done_q, neg_q;
  logic [DIV_NW-1:0] num_q, quo_q;
  logic [DIV_DW-1:0] rem_q, d_q;
  logic [DIV_CW-1:0] cnt_q;
  logic [DIV_DW:0]   trial, diff;
  logic              ge;

  assign trial = {rem_q, num_q[DIV_NW-1]};
  assign diff  = trial - {1'b0, d_q};
  assign ge    = trial >= {1'b0, d_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
      end else if (busy_q && cnt_q == '0) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= n_i[DIV_NW-1] ? DIV_NW'(-n_i) : DIV_NW'(n_i);
      neg_q <= n_i[DIV_NW-1];
      rem_q <= '0;
      quo_q <= '0;
      d_q   <= d_i;
      cnt_q <= DIV_CW'(DIV_NW - 1);
    end else if (busy_q) begin
      rem_q <= ge ? diff[DIV_DW-1:0] : trial[DIV_DW-1:0];
      quo_q <= {quo_q[DIV_NW-2:0], ge};
      num_q <= num_q << 1;
      cnt_q <= cnt_q - 1'b1;
    end
  end

  assign done_o = done_q;
  assign q_o    = neg_q ? -$signed(quo_q) : $signed(quo_q);

endmodule

// ===== hw/rtl/qapm_isqrt.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qapm_isqrt: digit-by-digit integer square root
// One result bit per cycle.
// ----------------------------------------------------------------------------
module qapm_isqrt import qapm_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [SQ_NW-1:0] n_i,
  output logic             done_o,
  output logic [SQ_RW-1:0] root_o
);

  localparam logic [SQ_NW-1:0] BIT0 = {2'b01, {(SQ_NW-2){1'b0}}};

  logic             busy_q, done_q;
  logic [SQ_NW-1:0] n_q, root_q, bit_q, trial;
  logic [SQ_CW-1:0] cnt_q;

  assign trial = root_q + bit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
      end else if (busy_q && cnt_q == '0) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      n_q    <= n_i;
      root_q <= '0;
      bit_q  <= BIT0;
      cnt_q  <= SQ_CW'(SQ_STEPS - 1);
    end else if (busy_q) begin
      if (n_q >= trial) begin
        n_q    <= n_q - trial;
        root_q <= (root_q >> 1) + bit_q;
      end else begin
        root_q <= root_q >> 1;
      end
      bit_q <= bit_q >> 2;
      cnt_q <= cnt_q - 1'b1;
    end
  end

  assign done_o = done_q;
  assign root_o = root_q[SQ_RW-1:0];

endmodule

// ===== hw/rtl/qapm_cordic.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qapm_cordic: vectoring CORDIC atan2
// One micro-rotation per cycle. Result in Q10.16 degrees; a zero vector
// gives zero, negative x is pre-rotated by 180.
// ----------------------------------------------------------------------------
module qapm_cordic import qapm_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic signed [CW-1:0] x_i,
  input  logic signed [CW-1:0] y_i,
  output logic                 done_o,
  output logic signed [ZW-1:0] z_o
);

  logic                 busy_q, done_q, zero_in;
  logic signed [CW-1:0] x_q, y_q, dx, dy;
  logic signed [ZW-1:0] z_q, ang;
  logic [CORDIC_IW-1:0] i_q;

  assign zero_in = (x_i == '0) && (y_i == '0);
  assign dx      = y_q >>> i_q;
  assign dy      = x_q >>> i_q;
  assign ang     = $signed(atan_deg(i_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= !zero_in;
        done_q <= zero_in;
      end else if (busy_q && i_q == CORDIC_IW'(CORDIC_STEPS - 1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      i_q <= '0;
      if (zero_in) begin
        z_q <= '0;
      end else if (x_i[CW-1]) begin
        z_q <= y_i[CW-1] ? -$signed(DEG180_Q16) : $signed(DEG180_Q16);
        x_q <= -x_i;
        y_q <= -y_i;
      end else begin
        z_q <= '0;
        x_q <= x_i;
        y_q <= y_i;
      end
    end else if (busy_q) begin
      if (!y_q[CW-1]) begin
        x_q <= x_q + dx;
        y_q <= y_q - dy;
        z_q <= z_q + ang;
      end else begin
        x_q <= x_q - dx;
        y_q <= y_q + dy;
        z_q <= z_q - ang;
      end
      i_q <= i_q + 1'b1;
    end
  end

  assign done_o = done_q;
  assign z_o    = z_q;

endmodule

// ===== hw/rtl/quad_attitude_pid_mixer_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quad_attitude_pid_mixer_unit: attitude filter, roll/pitch PID, X mixer
// Sequencer around a bit-serial multiplier, restoring divider, CORDIC atan2
// and integer square root, all shared.
// ----------------------------------------------------------------------------
// One control tick per input word, one result word per tick. A tick is
// worked on alone; its length is set by the bit-serial multiplier (one
// multiplier bit per cycle, stopping at the top set bit), the restoring
// divider run up to four times per armed tick, 16 CORDIC rotations twice
// and 24 square-root steps. The input side is ready only between ticks; a
// finished result waits in the output register while the next tick is taken
// in. Gain writes are always accepted and take effect at once, also for a
// tick under way; indexes above 5 are dropped.
// ----------------------------------------------------------------------------
module quad_attitude_pid_mixer_unit import qapm_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // throttle, target_roll, target_pitch, accel_x, accel_y, accel_z,
  // rate_x, rate_y, elapsed_us
  input  logic [119:0] s_axis_tdata,
  // arm_request
  input  logic [0:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // duty_front_left, duty_front_right, duty_rear_left, duty_rear_right,
  // roll_estimate, pitch_estimate
  output logic [63:0]  m_axis_tdata,
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [2:0]   cfg_index_i,
  input  logic [15:0]  cfg_data_i
);

  localparam logic [4:0] ST_IDLE     = 5'd0;
  localparam logic [4:0] ST_CORDIC_R = 5'd1;
  localparam logic [4:0] ST_SQ_Y     = 5'd2;
  localparam logic [4:0] ST_SQ_Z     = 5'd3;
  localparam logic [4:0] ST_SQRT     = 5'd4;
  localparam logic [4:0] ST_CORDIC_P = 5'd5;
  localparam logic [4:0] ST_GYRO1    = 5'd6;
  localparam logic [4:0] ST_GYRO2    = 5'd7;
  localparam logic [4:0] ST_KEEP     = 5'd8;
  localparam logic [4:0] ST_BLEND    = 5'd9;
  localparam logic [4:0] ST_ERR      = 5'd10;
  localparam logic [4:0] ST_EUS      = 5'd11;
  localparam logic [4:0] ST_EDIV     = 5'd12;
  localparam logic [4:0] ST_DIFF     = 5'd13;
  localparam logic [4:0] ST_DDIV     = 5'd14;
  localparam logic [4:0] ST_KP       = 5'd15;
  localparam logic [4:0] ST_KI       = 5'd16;
  localparam logic [4:0] ST_KD       = 5'd17;
  localparam logic [4:0] ST_OUT      = 5'd18;

  function automatic logic [7:0] duty8(input logic signed [41:0] m);
    if (m[41]) return 8'd0;
    if (|m[40:24]) return 8'd255;
    return m[23:16];
  endfunction

  function automatic logic [15:0] q88(input logic signed [STATE_W-1:0] v);
    logic [23:0] r;
    r = v[31:8];
    if (!r[23] && (|r[22:15])) return 16'h7fff;
    if (r[23] && !(&r[22:15])) return 16'h8000;
    return r[15:0];
  endfunction

  // control
  logic [4:0] state_q;
  logic       go_q, axis_q, m_valid_q, load_out;
  logic [15:0] gain_q [0:5];
  logic signed [STATE_W-1:0] est_q [0:1];
  logic signed [STATE_W-1:0] sum_q [0:1];
  logic signed [STATE_W-1:0] last_q [0:1];

  // captured word and working registers
  logic [7:0]        thr_q;
  logic signed [7:0] troll_q, tpitch_q;
  logic signed [15:0] ax_q, ay_q, az_q, gx_q, gy_q;
  logic [15:0]       us_q;
  logic              active_q;
  logic [31:0]       nsq_q;
  logic [SQ_RW-1:0]  root_q;
  logic signed [ZW-1:0] acc_roll_q, acc_pitch_q;
  logic signed [MUL_AW-1:0] t_q;
  logic signed [STATE_W-1:0] a_q, e_q, d_q;
  logic signed [MUL_PW-1:0] accum_q;
  logic signed [PID_W-1:0] pid_acc_q;
  logic signed [PID_W-1:0] pid_q [0:1];
  logic [63:0]       out_q;

  // unit handshakes
  logic mul_start, div_start, cor_start, sq_start, unit_start, unit_done;
  logic mul_done, div_done, cor_done, sq_done;
  logic signed [MUL_AW-1:0] mul_a;
  logic [MUL_BW-1:0]        mul_b;
  logic signed [MUL_PW-1:0] mul_p;
  logic [DIV_DW-1:0]        div_d;
  logic signed [DIV_NW-1:0] div_q;
  logic signed [CW-1:0]     cor_x, cor_y;
  logic signed [ZW-1:0]     cor_z;
  logic [SQ_RW-1:0]         sq_root;

  // datapath terms
  logic [16:0] ay_abs, az_abs;
  logic signed [16:0] ay_ext, az_ext;
  logic signed [15:0] rate_sel;
  logic signed [7:0]  tgt;
  logic signed [ZW-1:0] acc_ang;
  logic signed [STATE_W-1:0] est_cur, sum_cur, last_cur;
  logic signed [STATE_W:0]   diff;
  logic [2:0]  ksel, kidx;
  logic signed [MUL_PW-1:0] step_full, blend_sum;
  logic signed [STATE_W-1:0] a_d, blend_d, e_d, sum_d, dq_d;
  logic signed [PID_W-1:0]  gterm;
  logic signed [41:0] base, orl, opt;
  logic us_zero, is_mul_state;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign cfg_ready_o   = 1'b1;
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = out_q;
  assign load_out      = (state_q == ST_OUT) && (!m_valid_q || m_axis_tready);
  assign us_zero       = (us_q == '0);

  assign ay_ext   = 17'(ay_q);
  assign az_ext   = 17'(az_q);
  assign ay_abs   = ay_ext[16] ? 17'(-ay_ext) : 17'(ay_ext);
  assign az_abs   = az_ext[16] ? 17'(-az_ext) : 17'(az_ext);
  assign rate_sel = axis_q ? gy_q : gx_q;
  assign tgt      = axis_q ? tpitch_q : troll_q;
  assign acc_ang  = axis_q ? acc_pitch_q : acc_roll_q;
  assign est_cur  = est_q[axis_q];
  assign sum_cur  = sum_q[axis_q];
  assign last_cur = last_q[axis_q];
  assign diff     = 33'(e_q) - 33'(last_cur);

  always_comb begin
    unique case (state_q)
      ST_KP:   ksel = REG_ROLL_KP;
      ST_KI:   ksel = REG_ROLL_KI;
      default: ksel = REG_ROLL_KD;
    endcase
  end
  assign kidx = axis_q ? (ksel + REG_PITCH_KP) : ksel;

  // gyro step rounds half up; blend rounds the Q16 product
  assign step_full = mul_p + 58'sd2147483648;
  assign a_d       = sat_state(64'(est_cur) + 64'(step_full >>> 32));
  assign blend_sum = accum_q + mul_p + 58'sd32768;
  assign blend_d   = sat_state(64'(blend_sum >>> 16));
  assign e_d       = sat_state(64'($signed({tgt, 16'b0})) - 64'(est_cur));
  assign sum_d     = sat_state(64'(sum_cur) + 64'(div_q));
  assign dq_d      = sat_state(64'(div_q));
  assign gterm     = PID_W'(mul_p >>> 12);

  assign base = $signed({18'b0, thr_q, 16'b0});
  assign orl  = 42'(pid_q[0]);
  assign opt  = 42'(pid_q[1]);

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    is_mul_state = 1'b1;
    unique case (state_q)
      ST_SQ_Y:  begin mul_a = MUL_AW'(ay_abs);   mul_b = MUL_BW'(ay_abs); end
      ST_SQ_Z:  begin mul_a = MUL_AW'(az_abs);   mul_b = MUL_BW'(az_abs); end
      ST_GYRO1: begin mul_a = MUL_AW'(rate_sel); mul_b = MUL_BW'(us_q);   end
      ST_GYRO2: begin mul_a = t_q;               mul_b = GYRO_GAIN;       end
      ST_KEEP:  begin mul_a = MUL_AW'(a_q);      mul_b = KEEP_Q16;        end
      ST_BLEND: begin mul_a = MUL_AW'(acc_ang);  mul_b = BLEND_Q16;       end
      ST_EUS:   begin mul_a = MUL_AW'(e_q);      mul_b = MUL_BW'(us_q);   end
      ST_DIFF:  begin mul_a = MUL_AW'(diff);     mul_b = MUL_BW'(USEC_PER_SEC); end
      ST_KP:    begin mul_a = MUL_AW'(e_q);      mul_b = MUL_BW'(gain_q[kidx]); end
      ST_KI:    begin mul_a = MUL_AW'(sum_cur);  mul_b = MUL_BW'(gain_q[kidx]); end
      ST_KD:    begin mul_a = MUL_AW'(d_q);      mul_b = MUL_BW'(gain_q[kidx]); end
      default:  is_mul_state = 1'b0;
    endcase
  end

  assign mul_start = !go_q && is_mul_state && !(state_q == ST_DIFF && us_zero);
  assign div_start = !go_q && (state_q == ST_EDIV || state_q == ST_DDIV);
  assign cor_start = !go_q && (state_q == ST_CORDIC_R || state_q == ST_CORDIC_P);
  assign sq_start  = !go_q && (state_q == ST_SQRT);
  assign unit_start = mul_start || div_start || cor_start || sq_start;
  assign div_d = (state_q == ST_EDIV) ? USEC_PER_SEC : DIV_DW'(us_q);

  always_comb begin
    if (state_q == ST_CORDIC_R) begin
      cor_y = {{4{ay_q[15]}}, ay_q, 8'b0};
      cor_x = {{4{az_q[15]}}, az_q, 8'b0};
    end else begin
      cor_y = -$signed({{4{ax_q[15]}}, ax_q, 8'b0});
      cor_x = $signed({3'b0, root_q});
    end
  end

  always_comb begin
    unique case (state_q)
      ST_CORDIC_R, ST_CORDIC_P: unit_done = cor_done;
      ST_SQRT:                  unit_done = sq_done;
      ST_EDIV, ST_DDIV:         unit_done = div_done;
      default:                  unit_done = mul_done;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      go_q      <= 1'b0;
      axis_q    <= 1'b0;
      m_valid_q <= 1'b0;
      for (int i = 0; i < 2; i++) begin
        est_q[i]  <= '0;
        sum_q[i]  <= '0;
        last_q[i] <= '0;
      end
      gain_q[REG_ROLL_KP]  <= KP_RESET;
      gain_q[REG_ROLL_KI]  <= KI_RESET;
      gain_q[REG_ROLL_KD]  <= KD_RESET;
      gain_q[REG_PITCH_KP] <= KP_RESET;
      gain_q[REG_PITCH_KI] <= KI_RESET;
      gain_q[REG_PITCH_KD] <= KD_RESET;
    end else begin
      if (cfg_valid_i && cfg_index_i < NUM_GAINS) gain_q[cfg_index_i] <= cfg_data_i;
      if (load_out) m_valid_q <= 1'b1;
      else if (m_valid_q && m_axis_tready) m_valid_q <= 1'b0;
      if (unit_done) go_q <= 1'b0;
      else if (unit_start) go_q <= 1'b1;

      unique case (state_q)
        ST_IDLE: begin
          if (s_axis_tvalid) begin
            state_q <= ST_CORDIC_R;
            axis_q  <= 1'b0;
          end
        end
        ST_CORDIC_R: if (unit_done) state_q <= ST_SQ_Y;
        ST_SQ_Y:     if (unit_done) state_q <= ST_SQ_Z;
        ST_SQ_Z:     if (unit_done) state_q <= ST_SQRT;
        ST_SQRT:     if (unit_done) state_q <= ST_CORDIC_P;
        ST_CORDIC_P: if (unit_done) state_q <= ST_GYRO1;
        ST_GYRO1:    if (unit_done) state_q <= ST_GYRO2;
        ST_GYRO2:    if (unit_done) state_q <= ST_KEEP;
        ST_KEEP:     if (unit_done) state_q <= ST_BLEND;
        ST_BLEND: begin
          if (unit_done) begin
            est_q[axis_q] <= blend_d;
            if (!axis_q) begin
              axis_q  <= 1'b1;
              state_q <= ST_GYRO1;
            end else if (active_q) begin
              axis_q  <= 1'b0;
              state_q <= ST_ERR;
            end else begin
              // not active (disarmed or throttle low): PID state drops, duties go to zero
              for (int i = 0; i < 2; i++) begin
                sum_q[i]  <= '0;
                last_q[i] <= '0;
              end
              state_q <= ST_OUT;
            end
          end
        end
        ST_ERR:  state_q <= ST_EUS;
        ST_EUS:  if (unit_done) state_q <= ST_EDIV;
        ST_EDIV: begin
          if (unit_done) begin
            sum_q[axis_q] <= sum_d;
            state_q       <= ST_DIFF;
          end
        end
        ST_DIFF: begin
          if (us_zero) begin
            last_q[axis_q] <= e_q;
            state_q        <= ST_KP;
          end else if (unit_done) begin
            state_q <= ST_DDIV;
          end
        end
        ST_DDIV: begin
          if (unit_done) begin
            last_q[axis_q] <= e_q;
            state_q        <= ST_KP;
          end
        end
        ST_KP: if (unit_done) state_q <= ST_KI;
        ST_KI: if (unit_done) state_q <= ST_KD;
        ST_KD: begin
          if (unit_done) begin
            if (!axis_q) begin
              axis_q  <= 1'b1;
              state_q <= ST_ERR;
            end else begin
              state_q <= ST_OUT;
            end
          end
        end
        ST_OUT: begin
          if (load_out) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          thr_q    <= s_axis_tdata[7:0];
          troll_q  <= s_axis_tdata[15:8];
          tpitch_q <= s_axis_tdata[23:16];
          ax_q     <= s_axis_tdata[39:24];
          ay_q     <= s_axis_tdata[55:40];
          az_q     <= s_axis_tdata[71:56];
          gx_q     <= s_axis_tdata[87:72];
          gy_q     <= s_axis_tdata[103:88];
          us_q     <= s_axis_tdata[119:104];
          active_q <= s_axis_tuser[0] && (s_axis_tdata[7:0] > THROTTLE_MIN);
        end
      end
      ST_CORDIC_R: if (unit_done) acc_roll_q <= cor_z;
      ST_SQ_Y:     if (unit_done) nsq_q <= mul_p[31:0];
      ST_SQ_Z:     if (unit_done) nsq_q <= nsq_q + mul_p[31:0];
      ST_SQRT:     if (unit_done) root_q <= sq_root;
      ST_CORDIC_P: if (unit_done) acc_pitch_q <= cor_z;
      ST_GYRO1:    if (unit_done) t_q <= mul_p[MUL_AW-1:0];
      ST_GYRO2:    if (unit_done) a_q <= a_d;
      ST_KEEP:     if (unit_done) accum_q <= mul_p;
      ST_ERR:      e_q <= e_d;
      ST_EUS:      if (unit_done) accum_q <= mul_p;
      ST_DIFF: begin
        if (us_zero) d_q <= '0;
        else if (unit_done) accum_q <= mul_p;
      end
      ST_DDIV:     if (unit_done) d_q <= dq_d;
      ST_KP:       if (unit_done) pid_acc_q <= gterm;
      ST_KI:       if (unit_done) pid_acc_q <= pid_acc_q + gterm;
      ST_KD:       if (unit_done) pid_q[axis_q] <= pid_acc_q + gterm;
      ST_OUT: begin
        if (load_out) begin
          if (active_q) begin
            out_q[7:0]   <= duty8(base + opt + orl);
            out_q[15:8]  <= duty8(base + opt - orl);
            out_q[23:16] <= duty8(base - opt + orl);
            out_q[31:24] <= duty8(base - opt - orl);
          end else begin
            out_q[31:0] <= '0;
          end
          out_q[47:32] <= q88(est_q[0]);
          out_q[63:48] <= q88(est_q[1]);
        end
      end
      default: ;
    endcase
  end

  qapm_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .done_o  (mul_done),
    .p_o     (mul_p)
  );

  qapm_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .n_i     (accum_q),
    .d_i     (div_d),
    .done_o  (div_done),
    .q_o     (div_q)
  );

  qapm_isqrt u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sq_start),
    .n_i     ({nsq_q, 16'b0}),
    .done_o  (sq_done),
    .root_o  (sq_root)
  );

  qapm_cordic u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cor_start),
    .x_i     (cor_x),
    .y_i     (cor_y),
    .done_o  (cor_done),
    .z_o     (cor_z)
  );

endmodule

// ===== verif/quad_attitude_pid_mixer_unit_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quad_attitude_pid_mixer_unit_test: self-checking bench for the attitude unit
// Drives control ticks and gain writes, predicts every result word with a
// bit-exact model of the filter, PID and mixer, and compares field by field.
// ----------------------------------------------------------------------------
module quad_attitude_pid_mixer_unit_test;
  import qapm_pkg::*;

  typedef struct {
    logic        arm;
    logic [7:0]  thr;
    logic [7:0]  tgt_roll;
    logic [7:0]  tgt_pitch;
    logic [15:0] ax;
    logic [15:0] ay;
    logic [15:0] az;
    logic [15:0] gx;
    logic [15:0] gy;
    logic [15:0] dt;
  } tick_t;

  localparam longint SMAX = 64'sd2147483647;
  localparam longint SMIN = -64'sd2147483648;

  logic         clk_i;
  logic         rst_ni;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [119:0] s_axis_tdata;
  logic [0:0]   s_axis_tuser;
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  logic [63:0]  m_axis_tdata;
  logic         cfg_valid_i;
  logic         cfg_ready_o;
  logic [2:0]   cfg_index_i;
  logic [15:0]  cfg_data_i;

  quad_attitude_pid_mixer_unit dut (.*);

  tick_t       pending_ticks[$];
  logic [63:0] expected_words[$];
  logic [15:0] gain_reg[6];
  longint      roll_est, pitch_est, roll_sum, pitch_sum, roll_last, pitch_last;
  logic        in_fire;
  logic        no_idle;
  int          errors;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // ---------------- predictor ----------------
  function automatic longint sat32(longint v);
    return v > SMAX ? SMAX : (v < SMIN ? SMIN : v);
  endfunction

  function automatic longint atan_step(int i);
    longint tbl[24] = '{2949120, 1740967, 919879, 466945, 234379, 117304, 58666,
                        29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115, 57,
                        29, 14, 7, 4, 2, 1, 0};
    return tbl[i];
  endfunction

  function automatic longint vec_angle(longint y, longint x);
    longint z, dx, dy;
    z = 0;
    if (x == 0 && y == 0) return 0;
    // left half plane: rotate by 180 degrees first
    if (x < 0) begin
      z = (y >= 0) ? 64'sd11796480 : -64'sd11796480;
      x = -x;
      y = -y;
    end
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y >= 0) begin
        x += dx; y -= dy; z += atan_step(i);
      end else begin
        x -= dx; y += dy; z -= atan_step(i);
      end
    end
    return z;
  endfunction

  function automatic longint int_root(longint unsigned n);
    longint unsigned root, bitv;
    root = 0;
    bitv = 64'd1 << 46;
    for (int i = 0; i < 24; i++) begin
      if (n >= root + bitv) begin
        n -= root + bitv;
        root = (root >> 1) + bitv;
      end else begin
        root >>= 1;
      end
      bitv >>= 2;
    end
    return longint'(root);
  endfunction

  function automatic longint fuse_angle(longint est, longint rate, longint us,
                                        longint acc);
    longint gstep, a;
    gstep = (rate * us * 64'sd3937337 + (64'sd1 <<< 31)) >>> 32;
    a = sat32(est + gstep);
    return sat32((64'sd62915 * a + 64'sd2621 * acc + 64'sd32768) >>> 16);
  endfunction

  function automatic longint gain_term(longint k, longint v);
    longint hi, lo;
    hi = v >>> 12;
    lo = v - hi * 4096;
    return k * hi + ((k * lo) >>> 12);
  endfunction

  function automatic longint err_rate(longint diff, longint us);
    longint q, r;
    if (us == 0) return 0;
    q = diff / us;
    r = diff % us;
    if (q > SMAX / 1000000) return SMAX;
    if (q < -(SMAX / 1000000)) return SMIN;
    return sat32(q * 1000000 + (r * 1000000) / us);
  endfunction

  task automatic axis_pid(input longint tgt, input longint est, inout longint sum,
                          inout longint last, input int kbase, input longint us,
                          output longint u);
    longint e, d;
    e = sat32(tgt * 65536 - est);
    sum = sat32(sum + (e * us) / 1000000);
    d = err_rate(e - last, us);
    last = e;
    u = gain_term(gain_reg[kbase], e) + gain_term(gain_reg[kbase + 1], sum)
        + gain_term(gain_reg[kbase + 2], d);
  endtask

  function automatic logic [7:0] to_duty(longint m);
    longint q;
    q = m / 65536;
    return q < 0 ? 8'd0 : (q > 255 ? 8'd255 : q[7:0]);
  endfunction

  function automatic logic [15:0] to_q88(longint v);
    longint r;
    r = v >>> 8;
    if (r > 32767) r = 32767;
    if (r < -32768) r = -32768;
    return r[15:0];
  endfunction

  task automatic predict_tick(input tick_t t, output logic [63:0] w);
    longint ax, ay, az, us, acc_roll, acc_pitch, mag, u_roll, u_pitch, base;
    logic [7:0] fl, fr, rl, rr;
    ax = longint'($signed(t.ax));
    ay = longint'($signed(t.ay));
    az = longint'($signed(t.az));
    us = longint'(t.dt);
    fl = 0; fr = 0; rl = 0; rr = 0;
    acc_roll = vec_angle(ay * 256, az * 256);
    mag = int_root(longint'(ay * ay + az * az) << 16);
    acc_pitch = vec_angle(-ax * 256, mag);
    roll_est = fuse_angle(roll_est, longint'($signed(t.gx)), us, acc_roll);
    pitch_est = fuse_angle(pitch_est, longint'($signed(t.gy)), us, acc_pitch);
    if (t.arm && t.thr > THROTTLE_MIN) begin
      axis_pid(longint'($signed(t.tgt_roll)), roll_est, roll_sum, roll_last,
               REG_ROLL_KP, us, u_roll);
      axis_pid(longint'($signed(t.tgt_pitch)), pitch_est, pitch_sum, pitch_last,
               REG_PITCH_KP, us, u_pitch);
      base = longint'(t.thr) * 65536;
      fl = to_duty(base + u_pitch + u_roll);
      fr = to_duty(base + u_pitch - u_roll);
      rl = to_duty(base - u_pitch + u_roll);
      rr = to_duty(base - u_pitch - u_roll);
    end else begin
      roll_sum = 0; roll_last = 0; pitch_sum = 0; pitch_last = 0;
    end
    w = {to_q88(pitch_est), to_q88(roll_est), rr, rl, fr, fl};
  endtask

  // ---------------- driver ----------------
  always @(negedge clk_i) begin
    if (rst_ni) begin
      m_axis_tready <= no_idle || ($urandom_range(99) >= 27);
      if (!s_axis_tvalid || in_fire) begin
        if (pending_ticks.size() > 0 && (no_idle || $urandom_range(99) >= 27)) begin
          tick_t t;
          t = pending_ticks.pop_front();
          s_axis_tdata <= {t.dt, t.gy, t.gx, t.az, t.ay, t.ax, t.tgt_pitch,
                           t.tgt_roll, t.thr};
          s_axis_tuser <= t.arm;
          s_axis_tvalid <= 1'b1;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // ---------------- monitor ----------------
  always @(posedge clk_i) begin
    logic [63:0] w;
    tick_t t;
    in_fire <= s_axis_tvalid && s_axis_tready;
    if (rst_ni && s_axis_tvalid && s_axis_tready) begin
      {t.dt, t.gy, t.gx, t.az, t.ay, t.ax, t.tgt_pitch, t.tgt_roll, t.thr} = s_axis_tdata;
      t.arm = s_axis_tuser[0];
      predict_tick(t, w);
      expected_words.push_back(w);
    end
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_words.size() == 0) begin
        $display("%0t: unexpected result word %h", $realtime, m_axis_tdata);
        errors++;
      end else begin
        w = expected_words.pop_front();
        for (int f = 0; f < 6; f++) begin
          logic [15:0] e, a;
          e = (f < 4) ? 16'(w[f*8 +: 8]) : w[32 + (f-4)*16 +: 16];
          a = (f < 4) ? 16'(m_axis_tdata[f*8 +: 8]) : m_axis_tdata[32 + (f-4)*16 +: 16];
          if (e !== a) begin
            $display("%0t: field %0d expected %h actual %h", $realtime, f, e, a);
            errors++;
          end
        end
      end
    end
  end

  // ---------------- stimulus ----------------
  function automatic tick_t rand_tick(bit noise);
    tick_t t;
    t.arm = noise ? 1'($urandom) : ($urandom_range(9) != 0);
    t.thr = noise ? 8'($urandom) : 8'($urandom_range(255, 10));
    t.tgt_roll = noise ? 8'($urandom) : 8'($signed($urandom_range(60)) - 30);
    t.tgt_pitch = noise ? 8'($urandom) : 8'($signed($urandom_range(60)) - 30);
    t.ax = noise ? 16'($urandom) : 16'($urandom_range(5000) - 2500);
    t.ay = noise ? 16'($urandom) : 16'($urandom_range(5000) - 2500);
    t.az = noise ? 16'($urandom) : 16'($urandom_range(3500) - 1000);
    t.gx = noise ? 16'($urandom) : 16'($urandom_range(8000) - 4000);
    t.gy = noise ? 16'($urandom) : 16'($urandom_range(8000) - 4000);
    t.dt = noise ? 16'($urandom) : 16'($urandom_range(6000, 2000));
    if (!noise && $urandom_range(19) == 0) t.dt = 0;
    return t;
  endfunction

  task automatic run_ticks(int n, int noise_pct);
    repeat (n) pending_ticks.push_back(rand_tick($urandom_range(99) < noise_pct));
    do @(posedge clk_i);
    while (pending_ticks.size() != 0 || s_axis_tvalid || expected_words.size() != 0);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_gain(logic [2:0] idx, logic [15:0] val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx < NUM_GAINS) gain_reg[idx] = val;
  endtask

  task automatic load_gains(logic [15:0] kp, logic [15:0] ki, logic [15:0] kd);
    write_gain(REG_ROLL_KP, kp);
    write_gain(REG_ROLL_KI, ki);
    write_gain(REG_ROLL_KD, kd);
    write_gain(REG_PITCH_KP, kp);
    write_gain(REG_PITCH_KI, ki);
    write_gain(REG_PITCH_KD, kd);
    write_gain(3'd6, 16'hFFFF);  // out of range, dropped
    write_gain(3'd7, 16'h0000);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  initial begin
    tick_t t;
    errors = 0;
    no_idle = 1'b0;
    in_fire = 1'b0;
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = '0;
    m_axis_tready = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i = '0;
    gain_reg = '{KP_RESET, KI_RESET, KD_RESET, KP_RESET, KI_RESET, KD_RESET};
    roll_est = 0; pitch_est = 0; roll_sum = 0; pitch_sum = 0;
    roll_last = 0; pitch_last = 0;
    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed: extremes, zero vector, left half plane, zero dt, arm threshold
    t = '{1'b1, 8'd255, 8'h7F, 8'h80, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF,
          16'h7FFF, 16'hFFFF};
    repeat (3) pending_ticks.push_back(t);
    t = '{1'b1, 8'd255, 8'h80, 8'h7F, 16'h8000, 16'h8000, 16'h8000, 16'h8000,
          16'h8000, 16'hFFFF};
    repeat (4) pending_ticks.push_back(t);
    t = '{1'b1, 8'd100, 8'd0, 8'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd4000};
    pending_ticks.push_back(t);
    t.az = 16'hFC00; t.ay = 16'd300;
    pending_ticks.push_back(t);
    t.ay = 16'hFF00;
    pending_ticks.push_back(t);
    t.ay = 16'd0;  // y zero, x negative
    pending_ticks.push_back(t);
    t = '{1'b1, 8'd120, 8'd20, 8'hEC, 16'd500, 16'd200, 16'd2500, 16'd900,
          16'hFC00, 16'd0};
    pending_ticks.push_back(t);
    t.dt = 16'd4000;
    pending_ticks.push_back(t);
    t.thr = 8'd15;
    pending_ticks.push_back(t);
    t.thr = 8'd16;
    pending_ticks.push_back(t);
    t.arm = 1'b0;
    pending_ticks.push_back(t);
    t = '{1'b1, 8'd0, 8'd0, 8'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0};
    pending_ticks.push_back(t);
    run_ticks(0, 0);

    run_ticks(100, 15);
    load_gains(16'($urandom), 16'($urandom_range(2000)), 16'($urandom));
    no_idle = 1'b1;
    run_ticks(80, 15);
    no_idle = 1'b0;
    load_gains(16'hFFFF, 16'hFFFF, 16'hFFFF);
    run_ticks(60, 15);
    load_gains(16'h0000, 16'h0000, 16'h0000);
    run_ticks(50, 15);
    load_gains(16'd5325, 16'd41, 16'd2048);
    run_ticks(100, 15);

    repeat (800) @(posedge clk_i);
    if (errors == 0 && expected_words.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("Mismatches found");
    $finish;
  end

endmodule

// ===== quad_attitude_pid_mixer_unit.f =====
hw/rtl/qapm_pkg.sv
hw/rtl/qapm_mul.sv
hw/rtl/qapm_div.sv
hw/rtl/qapm_isqrt.sv
hw/rtl/qapm_cordic.sv
hw/rtl/quad_attitude_pid_mixer_unit.sv
verif/quad_attitude_pid_mixer_unit_test.sv
